// File: hdl/yplc_pkg.sv
// Shared types and constants for the YUV plane layout calculator.
`default_nettype none

package yplc_pkg;

   // Field widths of the request and result items
   localparam int unsigned ModeW   = 4;
   localparam int unsigned AddrW   = 32;
   localparam int unsigned DimW    = 13;
   localparam int unsigned LpsW    = 2;
   localparam int unsigned StrideW = 14;
   localparam int unsigned CpsW    = 3;

   // Packed stream widths, padded to whole bytes
   localparam int unsigned ReqDataW = 64;
   localparam int unsigned RspDataW = 160;

   // Format codes
   typedef enum logic [ModeW-1:0] {
      FMT_YV12 = 4'd0,
      FMT_IF09 = 4'd1,
      FMT_YVU9 = 4'd2,
      FMT_IYUV = 4'd3,
      FMT_Y42B = 4'd4,
      FMT_I420 = 4'd5,
      FMT_YV16 = 4'd6,
      FMT_YV24 = 4'd7,
      FMT_Y41B = 4'd8,
      FMT_UYVY = 4'd9,
      FMT_YUY2 = 4'd10,
      FMT_YVYU = 4'd11,
      FMT_HDYC = 4'd12
   } fmt_code_type;

   // One layout request
   typedef struct packed {
      logic [ModeW-1:0] mode;
      logic [AddrW-1:0] buffer_base;
      logic [DimW-1:0]  width;
      logic [DimW-1:0]  height;
   } req_type;

   // Decoded format properties
   typedef struct packed {
      logic       known;    // code is a supported format
      logic [1:0] hshift;   // log2 of horizontal subsampling
      logic [1:0] vshift;   // log2 of vertical subsampling
      logic       packed_fmt;
      logic       v_first;  // V plane stored before U
      logic [1:0] off_y;    // byte offsets inside a macropixel
      logic [1:0] off_u;
      logic [1:0] off_v;
   } fmt_type;

   // One layout result
   typedef struct packed {
      logic               ok;
      logic [LpsW-1:0]    luma_pixel_stride;
      logic [StrideW-1:0] luma_line_stride;
      logic [DimW-1:0]    chroma_width;
      logic [DimW-1:0]    chroma_height;
      logic [CpsW-1:0]    chroma_pixel_stride;
      logic [StrideW-1:0] chroma_line_stride;
      logic [AddrW-1:0]   luma_addr;
      logic [AddrW-1:0]   cb_addr;
      logic [AddrW-1:0]   cr_addr;
   } rsp_type;

endpackage

`default_nettype wire

// File: hdl/yuv_plane_layout_calc_unit.sv
// Top level of the YUV plane layout calculator.
//
// Usage:
//   A layout request enters on the req_ stream (format code in req_tuser,
//   base address and frame size in req_tdata). Each request gives exactly
//   one result item on the rsp_ stream: the valid flag in rsp_tuser and the
//   strides, chroma size and Y/U/V plane addresses in rsp_tdata.
//   A request is first held in one input register; the decode, two small
//   multipliers and the address adders then feed the result register,
//   which drives rsp_tvalid. One item per cycle is sustained while the
//   receiver keeps rsp_tready high.
//   Reset empties both registers; no result is shown until a request is
//   accepted after reset. When the receiver stalls, the result register
//   holds its item and the input register can still take one more request;
//   req_tready drops only when both are full and rsp_tready is low.
//   MAX_DIM sets the largest width and height accepted as valid.
`default_nettype none

module yuv_plane_layout_calc_unit #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request stream
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: buffer_base[31:0], width[44:32], height[57:45], zero pad
   input  wire logic [yplc_pkg::ReqDataW-1:0]    req_tdata,
   // tuser: mode[3:0]
   input  wire logic [yplc_pkg::ModeW-1:0]       req_tuser,
   // result stream
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: luma_pixel_stride[1:0], luma_line_stride[15:2],
   //   chroma_width[28:16], chroma_height[41:29], chroma_pixel_stride[44:42],
   //   chroma_line_stride[58:45], luma_addr[90:59], cb_addr[122:91],
   //   cr_addr[154:123], zero pad
   output logic [yplc_pkg::RspDataW-1:0]         rsp_tdata,
   // tuser: ok[0]
   output logic                                  rsp_tuser
);

   localparam int unsigned DimW  = yplc_pkg::DimW;
   localparam int unsigned AddrW = yplc_pkg::AddrW;

   logic               req_vld_ff;
   logic               req_vld_in;
   yplc_pkg::req_type  req_ff;
   yplc_pkg::req_type  req_in;
   logic               rsp_vld_ff;
   logic               rsp_vld_in;
   yplc_pkg::rsp_type  rsp_ff;
   yplc_pkg::rsp_type  rsp_in;
   yplc_pkg::fmt_type  fmt;
   logic               rsp_adv;
   logic               req_adv;

   // Pipeline flow: each register loads when empty or draining
   assign rsp_adv    = !rsp_vld_ff || rsp_tready;
   assign req_adv    = !req_vld_ff || rsp_adv;
   assign req_tready = req_adv;

   // Unpack request item
   always_comb begin
      req_in.mode        = req_tuser;
      req_in.buffer_base = req_tdata[AddrW-1:0];
      req_in.width       = req_tdata[AddrW +: DimW];
      req_in.height      = req_tdata[AddrW+DimW +: DimW];
   end

   assign req_vld_in = req_adv ? req_tvalid : req_vld_ff;
   assign rsp_vld_in = rsp_adv ? req_vld_ff : rsp_vld_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
      if (req_adv && req_tvalid) begin
         req_ff <= req_in;
      end
   end

   yplc_decode u_decode (
      .mode (req_ff.mode),
      .fmt  (fmt)
   );

   yplc_calc #(
      .MAX_DIM (MAX_DIM)
   ) u_calc (
      .req (req_ff),
      .fmt (fmt),
      .rsp (rsp_in)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      if (rsp_adv && req_vld_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   // Pack result item
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_ff.ok;
   assign rsp_tdata  = {5'd0,
                        rsp_ff.cr_addr,
                        rsp_ff.cb_addr,
                        rsp_ff.luma_addr,
                        rsp_ff.chroma_line_stride,
                        rsp_ff.chroma_pixel_stride,
                        rsp_ff.chroma_height,
                        rsp_ff.chroma_width,
                        rsp_ff.luma_line_stride,
                        rsp_ff.luma_pixel_stride};

endmodule

`default_nettype wire

// File: hdl/yplc_decode.sv
// Format code decoder: subsampling, packing and plane order per code.
`default_nettype none

module yplc_decode (
   input  wire logic [yplc_pkg::ModeW-1:0] mode,
   output yplc_pkg::fmt_type               fmt
);

   always_comb begin
      fmt            = '0;
      fmt.known      = 1'b1;
      case (yplc_pkg::fmt_code_type'(mode))
         yplc_pkg::FMT_YV12: begin
            fmt.hshift  = 2'd1;
            fmt.vshift  = 2'd1;
            fmt.v_first = 1'b1;
         end
         yplc_pkg::FMT_IYUV, yplc_pkg::FMT_I420: begin
            fmt.hshift = 2'd1;
            fmt.vshift = 2'd1;
         end
         yplc_pkg::FMT_IF09, yplc_pkg::FMT_YVU9: begin
            fmt.hshift  = 2'd2;
            fmt.vshift  = 2'd2;
            fmt.v_first = 1'b1;
         end
         yplc_pkg::FMT_Y42B: begin
            fmt.hshift = 2'd1;
         end
         yplc_pkg::FMT_YV16: begin
            fmt.hshift  = 2'd1;
            fmt.v_first = 1'b1;
         end
         yplc_pkg::FMT_YV24: begin
            fmt.v_first = 1'b1;
         end
         yplc_pkg::FMT_Y41B: begin
            fmt.hshift = 2'd2;
         end
         // packed 4:2:2, Y/U/V byte offsets in the macropixel
         yplc_pkg::FMT_YUY2: begin
            fmt.hshift     = 2'd1;
            fmt.packed_fmt = 1'b1;
            fmt.off_y      = 2'd0;
            fmt.off_u      = 2'd1;
            fmt.off_v      = 2'd3;
         end
         yplc_pkg::FMT_YVYU: begin
            fmt.hshift     = 2'd1;
            fmt.packed_fmt = 1'b1;
            fmt.off_y      = 2'd0;
            fmt.off_u      = 2'd3;
            fmt.off_v      = 2'd1;
         end
         yplc_pkg::FMT_UYVY, yplc_pkg::FMT_HDYC: begin
            fmt.hshift     = 2'd1;
            fmt.packed_fmt = 1'b1;
            fmt.off_y      = 2'd1;
            fmt.off_u      = 2'd0;
            fmt.off_v      = 2'd2;
         end
         default: begin
            fmt.known = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/yplc_calc.sv
// Layout arithmetic: checks, strides, chroma size and plane addresses.
`default_nettype none

module yplc_calc #(
   parameter int unsigned MAX_DIM = 4096
) (
   input  wire yplc_pkg::req_type req,
   input  wire yplc_pkg::fmt_type fmt,
   output yplc_pkg::rsp_type      rsp
);

   localparam int unsigned DimW    = yplc_pkg::DimW;
   localparam int unsigned StrideW = yplc_pkg::StrideW;
   localparam int unsigned AddrW   = yplc_pkg::AddrW;

   logic                    dims_ok;
   logic                    div_ok;
   logic                    ok;
   logic [DimW-1:0]         cw;
   logic [DimW-1:0]         ch;
   logic [StrideW-1:0]      lls;
   logic [2*DimW-1:0]       luma_size;
   logic [2*DimW-1:0]       chroma_size;
   logic [AddrW-1:0]        second_addr;
   logic [AddrW-1:0]        third_addr;

   // Range and divisibility checks
   always_comb begin
      dims_ok = (req.buffer_base != '0) && (req.width != '0) && (req.height != '0)
                && (32'(req.width) <= 32'(MAX_DIM)) && (32'(req.height) <= 32'(MAX_DIM));
      div_ok  = ((req.width[1:0] & ((2'd1 << fmt.hshift) - 2'd1)) == 2'd0)
                && ((req.height[1:0] & ((2'd1 << fmt.vshift) - 2'd1)) == 2'd0);
      ok      = fmt.known && dims_ok && div_ok;
   end

   // Chroma size and luma line stride
   assign cw  = req.width >> fmt.hshift;
   assign ch  = req.height >> fmt.vshift;
   assign lls = fmt.packed_fmt ? {req.width, 1'b0} : {1'b0, req.width};

   // Plane sizes for planar formats; luma line stride equals width there
   assign luma_size   = req.width * req.height;
   assign chroma_size = cw * ch;
   assign second_addr = req.buffer_base + AddrW'(luma_size);
   assign third_addr  = second_addr + AddrW'(chroma_size);

   // Assemble the result, all zero on failure
   always_comb begin
      rsp = '0;
      if (ok) begin
         rsp.ok               = 1'b1;
         rsp.luma_line_stride = lls;
         rsp.chroma_width     = cw;
         rsp.chroma_height    = ch;
         if (fmt.packed_fmt) begin
            rsp.luma_pixel_stride   = 2'd2;
            rsp.chroma_pixel_stride = 3'd4;
            rsp.chroma_line_stride  = lls;
            rsp.luma_addr           = req.buffer_base + AddrW'(fmt.off_y);
            rsp.cb_addr             = req.buffer_base + AddrW'(fmt.off_u);
            rsp.cr_addr             = req.buffer_base + AddrW'(fmt.off_v);
         end else begin
            rsp.luma_pixel_stride   = 2'd1;
            rsp.chroma_pixel_stride = 3'd1;
            rsp.chroma_line_stride  = {1'b0, cw};
            rsp.luma_addr           = req.buffer_base;
            rsp.cb_addr             = fmt.v_first ? third_addr : second_addr;
            rsp.cr_addr             = fmt.v_first ? second_addr : third_addr;
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/yplc_checker.sv
// Port-level checker for the layout calculator, bound to the top level.
`default_nettype none

module yplc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [yplc_pkg::RspDataW-1:0]    rsp_tdata,
   input wire logic                             rsp_tuser
);

   // No result shown right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A stalled item holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Failed layouts carry all-zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("failed layout with non-zero fields");

   // Pixel strides pair up: planar 1/1, packed 2/4
   a_stride_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[1:0] == 2'd1 && rsp_tdata[44:42] == 3'd1)
         || (rsp_tdata[1:0] == 2'd2 && rsp_tdata[44:42] == 3'd4))
      else $error("inconsistent pixel strides");

   // Packed formats share the luma line stride
   a_packed_line: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tdata[1:0] == 2'd2 |->
         rsp_tdata[58:45] == rsp_tdata[15:2])
      else $error("packed chroma line stride differs");

endmodule

bind yuv_plane_layout_calc_unit yplc_checker u_yplc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// File: dv/yuv_plane_layout_calc_unit_test.sv
// Self-checking testbench for the YUV plane layout calculator.
module yuv_plane_layout_calc_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MaxDim = 4096;

   // Idling styles for either side
   localparam int unsigned PaceNone  = 0;
   localparam int unsigned PaceFull  = 1;
   localparam int unsigned PaceLight = 2;

   // Extra wait used for the drain at the end
   localparam int unsigned DrainCycles = 8;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [yplc_pkg::ReqDataW-1:0] req_tdata = '0;
   logic [yplc_pkg::ModeW-1:0]    req_tuser = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [yplc_pkg::RspDataW-1:0] rsp_tdata;
   logic                          rsp_tuser;

   int unsigned send_pace = PaceFull;
   int unsigned recv_pace = PaceFull;

   // Expected layouts in order, and the comparison of each result item
   class layout_scoreboard;
      yplc_pkg::rsp_type due_layouts[$];
      int unsigned       faults = 0;

      // Plane layout of one request, computed independently of the block
      function yplc_pkg::rsp_type plan_layout(yplc_pkg::req_type r);
         yplc_pkg::rsp_type res;
         int unsigned hdiv, vdiv, w, h, base;
         int unsigned lps, lls, cw, ch, cps, cls, second, third;
         int unsigned oy, ou, ov;
         logic        ok, is_packed, v_before_u;
         res = '0;
         hdiv = 1;
         vdiv = 1;
         ok = 1'b1;
         is_packed = 1'b0;
         v_before_u = 1'b0;
         w = r.width;
         h = r.height;
         base = r.buffer_base;
         case (r.mode)
            yplc_pkg::FMT_YV12: begin
               hdiv = 2; vdiv = 2; v_before_u = 1'b1;
            end
            yplc_pkg::FMT_IYUV, yplc_pkg::FMT_I420: begin
               hdiv = 2; vdiv = 2;
            end
            yplc_pkg::FMT_IF09, yplc_pkg::FMT_YVU9: begin
               hdiv = 4; vdiv = 4; v_before_u = 1'b1;
            end
            yplc_pkg::FMT_Y42B: hdiv = 2;
            yplc_pkg::FMT_YV16: begin
               hdiv = 2; v_before_u = 1'b1;
            end
            yplc_pkg::FMT_YV24: v_before_u = 1'b1;
            yplc_pkg::FMT_Y41B: hdiv = 4;
            yplc_pkg::FMT_UYVY, yplc_pkg::FMT_YUY2, yplc_pkg::FMT_YVYU,
            yplc_pkg::FMT_HDYC: begin
               hdiv = 2; is_packed = 1'b1;
            end
            default: ok = 1'b0;
         endcase
         if (base == 0 || w == 0 || h == 0 || w > MaxDim || h > MaxDim)
            ok = 1'b0;
         if (ok && ((w % hdiv) != 0 || (h % vdiv) != 0))
            ok = 1'b0;
         if (!ok)
            return res;

         lps = is_packed ? 2 : 1;
         lls = w * lps;
         cw  = w / hdiv;
         ch  = h / vdiv;
         cps = is_packed ? 4 : 1;
         cls = is_packed ? lls : lls / hdiv;

         res.ok                  = 1'b1;
         res.luma_pixel_stride   = yplc_pkg::LpsW'(lps);
         res.luma_line_stride    = yplc_pkg::StrideW'(lls);
         res.chroma_width        = yplc_pkg::DimW'(cw);
         res.chroma_height       = yplc_pkg::DimW'(ch);
         res.chroma_pixel_stride = yplc_pkg::CpsW'(cps);
         res.chroma_line_stride  = yplc_pkg::StrideW'(cls);
         if (is_packed) begin
            // byte offsets of Y, U and V inside the 4-byte macropixel
            if (r.mode == yplc_pkg::FMT_YUY2) begin
               oy = 0; ou = 1; ov = 3;
            end else if (r.mode == yplc_pkg::FMT_YVYU) begin
               oy = 0; ou = 3; ov = 1;
            end else begin
               oy = 1; ou = 0; ov = 2;
            end
            res.luma_addr = base + oy;
            res.cb_addr   = base + ou;
            res.cr_addr   = base + ov;
         end else begin
            // whole planes back to back, wrapping at 2^32
            second = base + lls * h;
            third  = second + cls * ch;
            res.luma_addr = base;
            res.cb_addr   = v_before_u ? third : second;
            res.cr_addr   = v_before_u ? second : third;
         end
         return res;
      endfunction

      function void note_request(yplc_pkg::req_type r);
         due_layouts.push_back(plan_layout(r));
      endfunction

      function void match_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            faults++;
         end
      endfunction

      function void check_result(logic ok, logic [yplc_pkg::RspDataW-1:0] data);
         yplc_pkg::rsp_type want;
         if (due_layouts.size() == 0) begin
            $error("result item with no request outstanding");
            faults++;
            return;
         end
         want = due_layouts.pop_front();
         match_field("ok", 32'(want.ok), 32'(ok));
         match_field("luma_pixel_stride", 32'(want.luma_pixel_stride), 32'(data[1:0]));
         match_field("luma_line_stride", 32'(want.luma_line_stride), 32'(data[15:2]));
         match_field("chroma_width", 32'(want.chroma_width), 32'(data[28:16]));
         match_field("chroma_height", 32'(want.chroma_height), 32'(data[41:29]));
         match_field("chroma_pixel_stride", 32'(want.chroma_pixel_stride),
                     32'(data[44:42]));
         match_field("chroma_line_stride", 32'(want.chroma_line_stride),
                     32'(data[58:45]));
         match_field("luma_addr", want.luma_addr, data[90:59]);
         match_field("cb_addr", want.cb_addr, data[122:91]);
         match_field("cr_addr", want.cr_addr, data[154:123]);
         match_field("tdata pad", 32'd0, 32'(data[159:155]));
      endfunction
   endclass

   layout_scoreboard layouts = new();

   yuv_plane_layout_calc_unit #(
      .MAX_DIM(MaxDim)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle cycles before the next item on one side
   function automatic int unsigned idle_cycles(int unsigned pace);
      case (pace)
         PaceNone:  return 0;
         PaceLight: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
         default:   return $urandom_range(0, 13);
      endcase
   endfunction

   // Offer one request and hold it until accepted
   task automatic send_request(input logic [yplc_pkg::ModeW-1:0] mode,
                               input logic [yplc_pkg::AddrW-1:0] base,
                               input logic [yplc_pkg::DimW-1:0]  w,
                               input logic [yplc_pkg::DimW-1:0]  h);
      yplc_pkg::req_type r;
      int unsigned       gap;
      r.mode = mode;
      r.buffer_base = base;
      r.width = w;
      r.height = h;
      gap = idle_cycles(send_pace);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {(yplc_pkg::ReqDataW - yplc_pkg::AddrW - 2 * yplc_pkg::DimW)'(0),
                     h, w, base};
      do @(posedge clock); while (!req_tready);
      layouts.note_request(r);
   endtask

   // Random frame dimension, mostly valid and nicely divisible
   function automatic logic [yplc_pkg::DimW-1:0] pick_dim();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 65) return yplc_pkg::DimW'(4 * $urandom_range(1, MaxDim / 4));
      if (sel < 80) return yplc_pkg::DimW'($urandom_range(1, 64));
      if (sel < 90) return yplc_pkg::DimW'($urandom_range(1, MaxDim));
      if (sel < 97) return yplc_pkg::DimW'($urandom_range(0, 8191));
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return yplc_pkg::DimW'(1);
         2:       return yplc_pkg::DimW'(MaxDim);
         default: return yplc_pkg::DimW'(MaxDim + 1);
      endcase
   endfunction

   function automatic logic [yplc_pkg::AddrW-1:0] pick_base();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 5) return '0;
      if (sel < 20) return 32'hFF00_0000 | 32'($urandom_range(0, 32'h00FF_FFFF));
      return $urandom;
   endfunction

   // Result side: random stalls, check every accepted item
   initial begin
      int unsigned stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = idle_cycles(recv_pace);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         layouts.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // Reset, stimulus and final verdict
   initial begin
      logic [yplc_pkg::ModeW-1:0] mode;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: every format at a small legal size
      for (int f = yplc_pkg::FMT_YV12; f <= yplc_pkg::FMT_HDYC; f++)
         send_request(yplc_pkg::ModeW'(f), 32'h1000_0000, 13'd16, 13'd16);
      // unknown codes
      send_request(4'd13, 32'h0000_4000, 13'd16, 13'd16);
      send_request(4'd15, 32'hFFFF_FFFF, 13'd8191, 13'd8191);
      // absent buffer, zero and oversize dimensions
      send_request(yplc_pkg::FMT_I420, 32'h0000_0000, 13'd64, 13'd64);
      send_request(yplc_pkg::FMT_YV24, 32'h0000_0100, 13'd0, 13'd8);
      send_request(yplc_pkg::FMT_YV24, 32'h0000_0100, 13'd8, 13'd0);
      send_request(yplc_pkg::FMT_YUY2, 32'h0000_0100, 13'd4097, 13'd8);
      send_request(yplc_pkg::FMT_YUY2, 32'h0000_0100, 13'd8, 13'd4097);
      // largest frames, with address wrap past the top
      send_request(yplc_pkg::FMT_YV12, 32'hFFFF_F000, 13'd4096, 13'd4096);
      send_request(yplc_pkg::FMT_YVYU, 32'hFFFF_FFFF, 13'd4096, 13'd4096);
      // subsampling does not divide the size
      send_request(yplc_pkg::FMT_YV12, 32'h0000_2000, 13'd15, 13'd16);
      send_request(yplc_pkg::FMT_IF09, 32'h0000_2000, 13'd16, 13'd6);
      send_request(yplc_pkg::FMT_Y41B, 32'h0000_2000, 13'd6, 13'd3);
      send_request(yplc_pkg::FMT_HDYC, 32'h0000_2000, 13'd7, 13'd5);
      // small legal frames: odd height with horizontal-only or no subsampling
      send_request(yplc_pkg::FMT_Y42B, 32'h0000_0001, 13'd2, 13'd3);
      send_request(yplc_pkg::FMT_YV24, 32'h0000_0001, 13'd1, 13'd1);

      // random: mostly known formats and sensible sizes, some noise
      for (int n = 0; n < 850; n++) begin
         if (n % 100 == 0) begin
            send_pace = $urandom_range(PaceNone, PaceLight);
            recv_pace = $urandom_range(PaceNone, PaceLight);
         end
         if ($urandom_range(0, 99) < 88)
            mode = yplc_pkg::ModeW'($urandom_range(yplc_pkg::FMT_YV12, yplc_pkg::FMT_HDYC));
         else
            mode = yplc_pkg::ModeW'($urandom_range(13, 15));
         send_request(mode, pick_base(), pick_dim(), pick_dim());
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      // drain outstanding results, then a few spare cycles
      while (layouts.due_layouts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (layouts.due_layouts.size() != 0) begin
         $error("%0d expected result items never arrived", layouts.due_layouts.size());
         layouts.faults++;
      end
      if (layouts.faults == 0) begin
         $display("yuv_plane_layout_calc_unit test passed");
      end else begin
         $display("yuv_plane_layout_calc_unit test failed");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #3ms;
      $display("yuv_plane_layout_calc_unit test failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/yplc_pkg.sv
hdl/yplc_decode.sv
hdl/yplc_calc.sv
hdl/yuv_plane_layout_calc_unit.sv
hdl/yplc_checker.sv
dv/yuv_plane_layout_calc_unit_test.sv
